### rtl/mscg_pkg.sv
// Shared types and constants for the multi-stop colour gradient unit.
// No dependencies; imported by the blend unit and the top level.
`default_nettype none

package mscg_pkg;

  localparam int         CNT_W     = 4;
  localparam logic [3:0] CNT_RESET = 4'd2;
  localparam logic [7:0] ALPHA_FULL = 8'hFF;

  // red in the lowest byte, alpha in the highest
  typedef struct packed {
    logic [7:0] a;
    logic [7:0] b;
    logic [7:0] g;
    logic [7:0] r;
  } rgba_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FIRST,
    ST_LOAD,
    ST_SCAN,
    ST_BLEND,
    ST_EMIT
  } seq_st_e;

  typedef enum logic [2:0] {
    BL_IDLE,
    BL_MUL,
    BL_ADJ,
    BL_DIV,
    BL_DONE
  } blend_st_e;

endpackage

`default_nettype wire

### rtl/mscg_stop_mem.sv
// Stop table: one write port, one read port, registered read data.
// Generic storage; no dependency on the package.
`default_nettype none

module mscg_stop_mem #(
  parameter int DEPTH = 8,
  parameter int WIDTH = 48,
  parameter int AW    = $clog2(DEPTH)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

`default_nettype wire

### rtl/mscg_blend.sv
// Four-lane interpolator: left + floor((right - left) * off / span) per channel; alpha is forced to full
// unless inc_alpha_i is set. One multiply stage, a bias add, then eight restoring division steps. Uses mscg_pkg.
`default_nettype none

module mscg_blend #(
  parameter int LB = 16
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start_i,
  input  mscg_pkg::rgba_t    lcol_i,
  input  mscg_pkg::rgba_t    rcol_i,
  input  wire logic [LB-1:0] off_i,
  input  wire logic [LB-1:0] span_i,
  input  wire logic          inc_alpha_i,
  output logic               done_o,
  output mscg_pkg::rgba_t    col_o
);

  import mscg_pkg::*;

  localparam int PW = LB + 8;

  blend_st_e state_q, state_d;

  logic [3:0][7:0] lc, rc, res;
  logic [7:0]      l_q    [4];
  logic [7:0]      d_q    [4];
  logic            neg_q  [4];
  logic [PW-1:0]   prod_q [4];
  logic [PW-1:0]   rem_q  [4];
  logic [7:0]      quo_q  [4];
  logic [LB-1:0]   off_q, span_q;
  logic [PW-1:0]   dv_q;
  logic [2:0]      step_q;
  logic            inc_q;

  assign lc = lcol_i;
  assign rc = rcol_i;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      BL_IDLE: if (start_i) state_d = BL_MUL;
      BL_MUL:  state_d = BL_ADJ;
      BL_ADJ:  state_d = BL_DIV;
      BL_DIV:  if (step_q == 3'd7) state_d = BL_DONE;
      BL_DONE: state_d = BL_IDLE;
      default: state_d = BL_IDLE;
    endcase
  end

  always_comb begin
    done_o = (state_q == BL_DONE);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BL_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      BL_IDLE: begin
        if (start_i) begin
          for (int c = 0; c < 4; c++) begin
            l_q[c]   <= lc[c];
            neg_q[c] <= rc[c] < lc[c];
            d_q[c]   <= (rc[c] < lc[c]) ? lc[c] - rc[c] : rc[c] - lc[c];
          end
          off_q  <= off_i;
          span_q <= span_i;
          inc_q  <= inc_alpha_i;
        end
      end
      BL_MUL: begin
        for (int c = 0; c < 4; c++) begin
          prod_q[c] <= PW'(d_q[c]) * PW'(off_q);
        end
      end
      BL_ADJ: begin
        // bias turns the floor into a ceiling on falling channels
        for (int c = 0; c < 4; c++) begin
          rem_q[c] <= prod_q[c] + (neg_q[c] ? PW'(span_q) - PW'(1) : PW'(0));
          quo_q[c] <= '0;
        end
        dv_q   <= PW'(span_q) << 7;
        step_q <= '0;
      end
      BL_DIV: begin
        for (int c = 0; c < 4; c++) begin
          if (rem_q[c] >= dv_q) begin
            rem_q[c] <= rem_q[c] - dv_q;
            quo_q[c] <= {quo_q[c][6:0], 1'b1};
          end else begin
            quo_q[c] <= {quo_q[c][6:0], 1'b0};
          end
        end
        dv_q   <= dv_q >> 1;
        step_q <= step_q + 3'd1;
      end
      BL_DONE: ;
      default: ;
    endcase
  end

  always_comb begin
    for (int c = 0; c < 4; c++) begin
      res[c] = neg_q[c] ? l_q[c] - quo_q[c] : l_q[c] + quo_q[c];
    end
    if (!inc_q) begin
      res[3] = ALPHA_FULL;
    end
    col_o = rgba_t'(res);
  end

endmodule

`default_nettype wire

### rtl/multi_stop_color_gradient_unit.sv
// Multi-stop RGBA gradient: stop table writes and colour queries on one stream.
// Depends on mscg_pkg, mscg_stop_mem and mscg_blend.
//
//  channel  | dir | beat carries
//  s_axis   | in  | tuser: mode; tdata: stop_index, location, r, g, b, a, include_alpha
//  m_axis   | out | tuser: segment_found; tdata: r, g, b, a
//  cfg      | in  | stop_count, written on cfg_we_i
//
// A write beat gives no result.
// A query is answered directly at either end of the range or with a single stop; otherwise
// the stop memory is scanned one entry per cycle until a stop matches or brackets the
// location or the last stop is reached, and a bracketed pair is interpolated by the 8-step divider.
// Reset clears control and sets stop_count to 2; the stop table is not cleared.
// A new beat is taken while the previous result waits on m_axis; a result stalls in
// its last cycle until the output register is free.
`default_nettype none

module multi_stop_color_gradient_unit #(
  parameter int MAX_STOPS     = 8,
  parameter int LOCATION_BITS = 16,
  localparam int InW = ((LOCATION_BITS + 36 + 7) / 8) * 8
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            s_axis_tvalid,
  output logic                 s_axis_tready,
  // stop_index, location, red_in, green_in, blue_in, alpha_in, include_alpha
  input  wire logic [InW-1:0]  s_axis_tdata,
  // mode
  input  wire logic [0:0]      s_axis_tuser,
  output logic                 m_axis_tvalid,
  input  wire logic            m_axis_tready,
  // red_out, green_out, blue_out, alpha_out
  output logic      [31:0]     m_axis_tdata,
  // segment_found
  output logic      [0:0]      m_axis_tuser,
  input  wire logic            cfg_we_i,
  input  wire logic [mscg_pkg::CNT_W-1:0] cfg_wdata_i
);

  import mscg_pkg::*;

  localparam int LB = LOCATION_BITS;
  localparam int IW = $clog2(MAX_STOPS);
  localparam int MW = LB + 32;
  localparam logic [LB-1:0] LocMax = {LB{1'b1}};

  seq_st_e state_q, state_d;

  logic [CNT_W-1:0] cnt_q;
  logic [LB-1:0]    loc_q, prev_loc_q;
  logic             inc_q, direct_q, two_q;
  logic [IW-1:0]    last_q, idx_q, last_c;
  rgba_t            prev_col_q, res_col_q, out_col_q;
  logic             res_found_q, out_found_q, out_valid_q;

  logic             in_acc, in_mode, in_inc;
  logic [2:0]       in_idx;
  logic [LB-1:0]    in_loc;
  rgba_t            in_col;

  logic             mem_we, mem_re;
  logic [IW-1:0]    mem_raddr;
  logic [MW-1:0]    mem_rdata;
  logic [LB-1:0]    rd_loc;
  rgba_t            rd_col;

  logic             hit_c, brk_c, end_c, blend_start, blend_done, out_free;
  logic [LB-1:0]    cl_loc, off_c, span_c;
  rgba_t            blend_col;

  assign in_mode = s_axis_tuser[0];
  assign in_idx  = s_axis_tdata[2:0];
  assign in_loc  = s_axis_tdata[LB+2:3];
  assign in_col  = rgba_t'(s_axis_tdata[LB+34:LB+3]);
  assign in_inc  = s_axis_tdata[LB+35];

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign mem_we        = in_acc && !in_mode && (32'(in_idx) < MAX_STOPS);

  always_comb begin
    if (cnt_q == '0) begin
      last_c = '0;
    end else if (32'(cnt_q) > MAX_STOPS) begin
      last_c = IW'(MAX_STOPS - 1);
    end else begin
      last_c = IW'(cnt_q - CNT_W'(1));
    end
  end

  mscg_stop_mem #(
    .DEPTH (MAX_STOPS),
    .WIDTH (MW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (IW'(in_idx)),
    .wdata_i ({in_loc, in_col}),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  assign rd_loc = mem_rdata[MW-1:32];
  assign rd_col = rgba_t'(mem_rdata[31:0]);

  assign hit_c = !two_q && (rd_loc == loc_q);
  assign brk_c = two_q ? (rd_loc > prev_loc_q)
                       : ((prev_loc_q < loc_q) && (loc_q < rd_loc));
  assign end_c = (idx_q == last_q);

  // saturate to the segment before taking the offset
  always_comb begin
    if (loc_q < prev_loc_q) begin
      cl_loc = prev_loc_q;
    end else if (loc_q > rd_loc) begin
      cl_loc = rd_loc;
    end else begin
      cl_loc = loc_q;
    end
    off_c  = cl_loc - prev_loc_q;
    span_c = rd_loc - prev_loc_q;
  end

  mscg_blend #(
    .LB (LB)
  ) u_blend (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (blend_start),
    .lcol_i      (prev_col_q),
    .rcol_i      (rd_col),
    .off_i       (off_c),
    .span_i      (span_c),
    .inc_alpha_i (inc_q),
    .done_o      (blend_done),
    .col_o       (blend_col)
  );

  assign out_free = !out_valid_q || m_axis_tready;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (in_acc && in_mode) state_d = ST_FIRST;
      ST_FIRST: state_d = ST_LOAD;
      ST_LOAD:  state_d = direct_q ? ST_EMIT : ST_SCAN;
      ST_SCAN: begin
        priority if (hit_c) state_d = ST_EMIT;
        else if (brk_c)     state_d = ST_BLEND;
        else if (end_c)     state_d = ST_EMIT;
        else                state_d = ST_SCAN;
      end
      ST_BLEND: if (blend_done) state_d = ST_EMIT;
      ST_EMIT:  if (out_free) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    mem_re      = 1'b0;
    mem_raddr   = '0;
    blend_start = 1'b0;
    unique case (state_q)
      ST_FIRST: begin
        mem_re    = 1'b1;
        mem_raddr = (loc_q == LocMax) ? last_q : '0;
      end
      ST_LOAD: begin
        mem_re    = !direct_q;
        mem_raddr = IW'(1);
      end
      ST_SCAN: begin
        mem_re      = !hit_c && !brk_c && !end_c;
        mem_raddr   = idx_q + IW'(1);
        blend_start = !hit_c && brk_c;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= CNT_RESET;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        cnt_q <= cfg_wdata_i;
      end
      if (state_q == ST_EMIT && out_free) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && in_mode) begin
      loc_q    <= in_loc;
      inc_q    <= in_inc;
      last_q   <= last_c;
      two_q    <= (last_c == IW'(1));
      direct_q <= (last_c == '0) || (in_loc == '0) || (in_loc == LocMax);
    end
    unique case (state_q)
      ST_LOAD: begin
        if (direct_q) begin
          res_col_q   <= rd_col;
          res_found_q <= 1'b1;
        end else begin
          prev_loc_q <= rd_loc;
          prev_col_q <= rd_col;
          idx_q      <= IW'(1);
        end
      end
      ST_SCAN: begin
        priority if (hit_c) begin
          res_col_q   <= rd_col;
          res_found_q <= 1'b1;
        end else if (brk_c) begin
          res_found_q <= 1'b1;
        end else if (end_c) begin
          res_col_q   <= '0;
          res_found_q <= 1'b0;
        end else begin
          prev_loc_q <= rd_loc;
          prev_col_q <= rd_col;
          idx_q      <= idx_q + IW'(1);
        end
      end
      ST_BLEND: begin
        if (blend_done) begin
          res_col_q <= blend_col;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          out_col_q   <= res_col_q;
          out_found_q <= res_found_q;
        end
      end
      default: ;
    endcase
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_col_q;
  assign m_axis_tuser  = out_found_q;

  a_done_in_blend: assert property (@(posedge clk_i) disable iff (!rst_ni)
    blend_done |-> state_q == ST_BLEND)
    else $error("blend result outside the blend wait");

  a_out_from_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(state_q) == ST_EMIT)
    else $error("result beat raised outside the emit step");

  a_zero_when_missed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tuser[0]) |-> m_axis_tdata == '0)
    else $error("colour not zero on a missed segment");

  a_scan_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_SCAN |-> idx_q <= last_q)
    else $error("scan index past the last stop");

endmodule

`default_nettype wire
